// ===== rtl/blr_pkg.sv =====
// Shared constants for the line rasteriser: default coordinate width,
// colour word width and the beat kind codes. No dependencies.
package blr_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COLOUR_WIDTH    = 32;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

endpackage

// ===== rtl/blr_in_reg.sv =====
// Input register for the line rasteriser: holds one beat of packed payload
// between the input channel and the stepping core. Standalone.
module blr_in_reg
#(
    parameter int DATA_WIDTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  item_valid,
    input  logic                  item_ready,
    output logic [DATA_WIDTH-1:0] item_data
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;

    assign in_ready   = !valid_reg || item_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign item_valid = valid_reg;
    assign item_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/blr_core.sv =====
// Line set-up, Bresenham stepping state and the pixel result register.
// Depends on blr_pkg.
module blr_core
    import blr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          item_kind,
    input  logic signed [COORD_WIDTH-1:0] item_start_x,
    input  logic signed [COORD_WIDTH-1:0] item_start_y,
    input  logic signed [COORD_WIDTH-1:0] item_end_x,
    input  logic signed [COORD_WIDTH-1:0] item_end_y,
    input  logic [COLOUR_WIDTH-1:0]       item_colour,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] pixel_x,
    output logic signed [COORD_WIDTH-1:0] pixel_y,
    output logic [COLOUR_WIDTH-1:0]       pixel_colour,
    output logic                          last_pixel
);

    localparam int DiffWidth = COORD_WIDTH + 1;
    localparam int ErrWidth  = COORD_WIDTH + 3;

    // line state
    logic [COORD_WIDTH-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_WIDTH-1:0]  cur_y_reg, cur_y_next;
    logic [COORD_WIDTH-1:0]  major_end_reg, major_end_next;
    logic [ErrWidth-1:0]     err_reg, err_next;
    logic [COORD_WIDTH-1:0]  dmaj_reg, dmaj_next;
    logic [COORD_WIDTH-1:0]  dmin_reg, dmin_next;
    logic                    down_reg, down_next;
    logic                    steep_reg, steep_next;
    logic                    active_reg, active_next;
    logic [COLOUR_WIDTH-1:0] colour_reg, colour_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [COORD_WIDTH-1:0]  px_reg, px_next;
    logic [COORD_WIDTH-1:0]  py_reg, py_next;
    logic [COLOUR_WIDTH-1:0] pc_reg, pc_next;
    logic                    last_reg, last_next;

    // set-up
    logic [DiffWidth-1:0]   dx, dy, ndx, ndy;
    logic [COORD_WIDTH-1:0] adx, ady;
    logic                   ld_steep, ld_swap, ld_minor_neg, ld_minor_zero;
    logic [COORD_WIDTH-1:0] ld_dmaj, ld_dmin, ld_end, ld_x, ld_y;
    logic [ErrWidth-1:0]    ld_err;

    // stepping
    logic [COORD_WIDTH-1:0] maj, mnr, maj_step, mnr_step;
    logic                   at_end, err_pos;
    logic [ErrWidth-1:0]    err_inc, err_step;

    logic emit, out_free, take;

    always_comb
    begin
        dx  = {item_end_x[COORD_WIDTH-1], item_end_x}
            - {item_start_x[COORD_WIDTH-1], item_start_x};
        dy  = {item_end_y[COORD_WIDTH-1], item_end_y}
            - {item_start_y[COORD_WIDTH-1], item_start_y};
        ndx = -dx;
        ndy = -dy;
        adx = dx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
        ady = dy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];

        ld_steep      = !(ady < adx);
        ld_swap       = ld_steep ? dy[COORD_WIDTH] : dx[COORD_WIDTH];
        ld_minor_neg  = ld_steep ? dx[COORD_WIDTH] : dy[COORD_WIDTH];
        ld_minor_zero = ld_steep ? (adx == '0) : (ady == '0);
        ld_dmaj       = ld_steep ? ady : adx;
        ld_dmin       = ld_steep ? adx : ady;
        ld_x          = ld_swap ? item_end_x : item_start_x;
        ld_y          = ld_swap ? item_end_y : item_start_y;
        if (ld_steep)
        begin
            ld_end = ld_swap ? item_start_y : item_end_y;
        end
        else
        begin
            ld_end = ld_swap ? item_start_x : item_end_x;
        end
        ld_err = {2'b00, ld_dmin, 1'b0} - {3'b000, ld_dmaj};
    end

    always_comb
    begin
        maj      = steep_reg ? cur_y_reg : cur_x_reg;
        mnr      = steep_reg ? cur_x_reg : cur_y_reg;
        at_end   = (maj == major_end_reg);
        err_pos  = !err_reg[ErrWidth-1] && (err_reg != '0);
        maj_step = maj + COORD_WIDTH'(1);
        if (err_pos)
        begin
            mnr_step = down_reg ? (mnr - COORD_WIDTH'(1)) : (mnr + COORD_WIDTH'(1));
            err_inc  = {3'b000, dmin_reg} - {3'b000, dmaj_reg};
        end
        else
        begin
            mnr_step = mnr;
            err_inc  = {3'b000, dmin_reg};
        end
        err_step = err_reg + {err_inc[ErrWidth-2:0], 1'b0};
    end

    assign emit       = (item_kind == KIND_STEP) && active_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign item_ready = !emit || out_free;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        err_next       = err_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        down_next      = down_reg;
        steep_next     = steep_reg;
        active_next    = active_reg;
        colour_next    = colour_reg;
        out_valid_next = out_valid_reg && !out_ready;
        px_next        = px_reg;
        py_next        = py_reg;
        pc_next        = pc_reg;
        last_next      = last_reg;

        if (take && (item_kind == KIND_LOAD))
        begin
            cur_x_next     = ld_x;
            cur_y_next     = ld_y;
            major_end_next = ld_end;
            err_next       = ld_err;
            dmaj_next      = ld_dmaj;
            dmin_next      = ld_dmin;
            down_next      = ld_minor_neg ^ ld_swap && !ld_minor_zero;
            steep_next     = ld_steep;
            active_next    = 1'b1;
            colour_next    = item_colour;
        end
        else if (take && emit)
        begin
            out_valid_next = 1'b1;
            px_next        = cur_x_reg;
            py_next        = cur_y_reg;
            pc_next        = colour_reg;
            last_next      = at_end;
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next   = err_step;
                cur_x_next = steep_reg ? mnr_step : maj_step;
                cur_y_next = steep_reg ? maj_step : mnr_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        major_end_reg <= major_end_next;
        err_reg       <= err_next;
        dmaj_reg      <= dmaj_next;
        dmin_reg      <= dmin_next;
        down_reg      <= down_next;
        steep_reg     <= steep_next;
        colour_reg    <= colour_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pc_reg        <= pc_next;
        last_reg      <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign pixel_colour = pc_reg;
    assign last_pixel   = last_reg;

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasteriser, top level: input register feeding the stepping core.
// Depends on blr_pkg, blr_in_reg and blr_core.
//
// A load beat (kind 0) sets up a line and gives no pixel; each step beat (kind 1)
// gives the next pixel of the active line, with last_pixel marking the final
// endpoint, and nothing when no line is active. One beat is taken every clock
// unless the result register holds a step beat back; a pixel is held first in the
// input register and then in the result register, with one add and compare of
// the error term between them. A full result register that is not drained
// holds back step beats of an active line; a load beat in the input register still passes.
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic [COLOUR_WIDTH-1:0]       colour,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] pixel_x,
    output logic signed [COORD_WIDTH-1:0] pixel_y,
    output logic [COLOUR_WIDTH-1:0]       pixel_colour,
    output logic                          last_pixel
);

    localparam int ItemWidth = 1 + 4 * COORD_WIDTH + COLOUR_WIDTH;
    localparam int ColLo     = 0;
    localparam int EyLo      = COLOUR_WIDTH;
    localparam int ExLo      = EyLo + COORD_WIDTH;
    localparam int SyLo      = ExLo + COORD_WIDTH;
    localparam int SxLo      = SyLo + COORD_WIDTH;
    localparam int KindBit   = SxLo + COORD_WIDTH;

    logic [ItemWidth-1:0] in_data;
    logic [ItemWidth-1:0] item_data;
    logic                 item_valid;
    logic                 item_ready;

    assign in_data = {kind, start_x, start_y, end_x, end_y, colour};

    blr_in_reg #(
        .DATA_WIDTH (ItemWidth)
    ) u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data)
    );

    blr_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_kind    (item_data[KindBit]),
        .item_start_x (item_data[SxLo +: COORD_WIDTH]),
        .item_start_y (item_data[SyLo +: COORD_WIDTH]),
        .item_end_x   (item_data[ExLo +: COORD_WIDTH]),
        .item_end_y   (item_data[EyLo +: COORD_WIDTH]),
        .item_colour  (item_data[ColLo +: COLOUR_WIDTH]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

endmodule
